/* sv/pfse_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// pfse_pkg
// Types, character codes and helpers shared by the format signature blocks.
// ============================================================================
package pfse_pkg;

    localparam int SIG_CAPACITY_DEF = 64;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam int USED_W           = 6;
    localparam int LEN_W            = 6;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_L       = 8'h6C;
    localparam logic [7:0] CH_Z       = 8'h7A;
    localparam logic [7:0] CH_J       = 8'h6A;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_BIG_L   = 8'h4C;

    typedef enum logic [2:0] {
        PH_PLAIN       = 3'd0,
        PH_PCT         = 3'd1,
        PH_FLAGS       = 3'd2,
        PH_WDIGITS     = 3'd3,
        PH_AFTER_WIDTH = 3'd4,
        PH_PREC_START  = 3'd5,
        PH_PDIGITS     = 3'd6,
        PH_LENGTH      = 3'd7
    } phase_t;

    // one queued job: up to three results caused by one item
    typedef struct packed {
        logic [1:0]            n;
        logic [2:0][7:0]       chars;
        logic                  status;
        logic                  ok;
        logic [LEN_W-1:0]      len_last;
    } job_t;

    function automatic logic is_flag(input logic [7:0] c);
        return c == CH_MINUS || c == CH_PLUS || c == CH_SPACE || c == CH_HASH
            || c == CH_ZERO;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_modifier(input logic [7:0] c);
        return c == CH_H || c == CH_L || c == CH_Z || c == CH_J || c == CH_T
            || c == CH_BIG_L;
    endfunction

endpackage

/* sv/pfse_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// pfse_front
// Parser: classifies each format byte and builds the job of results it causes.
// ============================================================================
module pfse_front #(
    parameter int SIGNATURE_CAPACITY = pfse_pkg::SIG_CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         format_char,
    output logic               push,
    output pfse_pkg::job_t     job
);
    import pfse_pkg::*;

    localparam logic [7:0] CAP = 8'(SIGNATURE_CAPACITY);

    phase_t              phase_reg, phase_next;
    logic [1:0][7:0]     lbuf_reg, lbuf_next;
    logic [1:0]          lcount_reg, lcount_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic                failed_reg, failed_next;

    logic [7:0]          c;
    phase_t              ph;
    logic                cont;
    logic                star_hit;
    phase_t              star_phase;
    logic [7:0]          used_wide;

    assign c         = format_char;
    assign used_wide = {{(8-USED_W){1'b0}}, used_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        lbuf_next   = lbuf_reg;
        lcount_next = lcount_reg;
        used_next   = used_reg;
        failed_next = failed_reg;
        job         = '0;
        push        = 1'b0;
        ph          = phase_reg;
        cont        = 1'b1;
        star_hit    = 1'b0;
        star_phase  = PH_AFTER_WIDTH;

        if (c == CH_NUL)
        begin
            push         = accept;
            job.n        = 2'd1;
            job.status   = 1'b1;
            job.ok       = !failed_reg && phase_reg == PH_PLAIN;
            job.len_last = LEN_W'(used_reg);
            phase_next   = PH_PLAIN;
            lbuf_next    = '0;
            lcount_next  = '0;
            used_next    = '0;
            failed_next  = 1'b0;
        end
        else if (!failed_reg)
        begin
            if (ph == PH_PLAIN)
            begin
                if (c == CH_PERCENT)
                    phase_next = PH_PCT;
                cont = 1'b0;
            end
            if (cont && ph == PH_PCT)
            begin
                if (c == CH_PERCENT)
                begin
                    phase_next = PH_PLAIN;
                    cont       = 1'b0;
                end
                else
                    ph = PH_FLAGS;
            end
            if (cont && ph == PH_FLAGS)
            begin
                if (is_flag(c))
                begin
                    phase_next = PH_FLAGS;
                    cont       = 1'b0;
                end
                else if (c == CH_STAR)
                begin
                    star_hit   = 1'b1;
                    star_phase = PH_AFTER_WIDTH;
                    cont       = 1'b0;
                end
                else if (is_digit(c))
                begin
                    phase_next = PH_WDIGITS;
                    cont       = 1'b0;
                end
                else
                    ph = PH_AFTER_WIDTH;
            end
            if (cont && ph == PH_WDIGITS)
            begin
                if (is_digit(c))
                    cont = 1'b0;
                else
                    ph = PH_AFTER_WIDTH;
            end
            if (cont && ph == PH_AFTER_WIDTH)
            begin
                if (c == CH_DOT)
                begin
                    phase_next = PH_PREC_START;
                    cont       = 1'b0;
                end
                else
                    ph = PH_LENGTH;
            end
            if (cont && ph == PH_PREC_START)
            begin
                if (c == CH_STAR)
                begin
                    star_hit   = 1'b1;
                    star_phase = PH_LENGTH;
                    cont       = 1'b0;
                end
                else if (is_digit(c))
                begin
                    phase_next = PH_PDIGITS;
                    cont       = 1'b0;
                end
                else
                    ph = PH_LENGTH;
            end
            if (cont && ph == PH_PDIGITS)
            begin
                if (is_digit(c))
                    cont = 1'b0;
            end

            if (star_hit)
            begin
                if (used_wide + 8'd2 >= CAP)
                    failed_next = 1'b1;
                else
                begin
                    used_next    = used_reg + USED_W'(1);
                    push         = accept;
                    job.n        = 2'd1;
                    job.chars[0] = CH_STAR;
                    job.len_last = LEN_W'(used_next);
                    phase_next   = star_phase;
                end
            end
            else if (cont)
            begin
                if (is_modifier(c) && lcount_reg < 2'd2)
                begin
                    lbuf_next[lcount_reg[0]] = c;
                    lcount_next              = lcount_reg + 2'd1;
                    phase_next               = PH_LENGTH;
                end
                else if (used_wide + 8'(lcount_reg) + 8'd2 >= CAP)
                    failed_next = 1'b1;
                else
                begin
                    used_next    = used_reg + USED_W'(lcount_reg) + USED_W'(1);
                    push         = accept;
                    job.n        = lcount_reg + 2'd1;
                    case (lcount_reg)
                        2'd0:    job.chars[0] = c;
                        2'd1:
                        begin
                            job.chars[0] = lbuf_reg[0];
                            job.chars[1] = c;
                        end
                        default:
                        begin
                            job.chars[0] = lbuf_reg[0];
                            job.chars[1] = lbuf_reg[1];
                            job.chars[2] = c;
                        end
                    endcase
                    job.len_last = LEN_W'(used_next);
                    lbuf_next    = '0;
                    lcount_next  = '0;
                    phase_next   = PH_PLAIN;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PLAIN;
            lbuf_reg   <= '0;
            lcount_reg <= '0;
            used_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            lbuf_reg   <= lbuf_next;
            lcount_reg <= lcount_next;
            used_reg   <= used_next;
            failed_reg <= failed_next;
        end
    end

endmodule

/* sv/pfse_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// pfse_queue
// Short job queue between parser and result sequencer.
// ============================================================================
module pfse_queue #(
    parameter int DEPTH = pfse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pfse_pkg::job_t     push_job,
    input  logic               pop,
    output logic               full,
    output logic               nonempty,
    output pfse_pkg::job_t     head
);
    import pfse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full     = cnt_reg == FULL_CNT;
    assign nonempty = cnt_reg != '0;
    assign head     = mem_reg[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_next  = do_push ? ((wr_reg == LAST) ? '0 : wr_reg + PTR_W'(1)) : wr_reg;
        rd_next  = do_pop  ? ((rd_reg == LAST) ? '0 : rd_reg + PTR_W'(1)) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_job;
    end

endmodule

/* sv/pfse_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// pfse_back
// Result sequencer: plays out each queued job one result per cycle while sig_ready is high.
// ============================================================================
module pfse_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_nonempty,
    input  pfse_pkg::job_t              q_head,
    output logic                        q_pop,
    output logic                        sig_valid,
    input  logic                        sig_ready,
    output logic [7:0]                  sig_char,
    output logic                        is_status,
    output logic                        ok,
    output logic [pfse_pkg::LEN_W-1:0]  sig_length,
    output logic                        last_of_run
);
    import pfse_pkg::*;

    job_t        cur_reg, cur_next;
    logic        busy_reg, busy_next;
    logic [1:0]  idx_reg, idx_next;
    logic        fire, load;

    assign sig_valid   = busy_reg;
    assign sig_char    = cur_reg.chars[idx_reg];
    assign is_status   = cur_reg.status;
    assign ok          = cur_reg.ok;
    assign last_of_run = idx_reg == cur_reg.n - 2'd1;
    assign sig_length  = cur_reg.len_last - LEN_W'(cur_reg.n) + LEN_W'(1) + LEN_W'(idx_reg);

    assign fire  = busy_reg && sig_ready;
    assign load  = !busy_reg || (fire && last_of_run);
    assign q_pop = load && q_nonempty;

    always_comb
    begin
        cur_next  = cur_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = q_nonempty;
            cur_next  = q_head;
            idx_next  = '0;
        end
        else if (fire)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

/* sv/printf_format_signature_extractor.sv */
`timescale 1ns / 1ps
// ============================================================================
// printf_format_signature_extractor
// Extracts the argument signature of a printf-style format string.
// ============================================================================
//  channel   handshake                  payload
//  input     format_valid/format_ready  format_char
//  output    sig_valid/sig_ready        sig_char, is_status, ok, sig_length,
//                                       last_of_run
//
//  The parser takes a byte per cycle while format_ready, registering its phase.
//  It yields 0 to 3 results; the sequencer sends one per cycle while sig_ready.
//  A QUEUE_DEPTH job queue decouples the two; format_ready drops only when full.
//  Reset clears parser state, queue and sequencer; no clearing pass.
// ============================================================================
module printf_format_signature_extractor #(
    parameter int SIGNATURE_CAPACITY = pfse_pkg::SIG_CAPACITY_DEF,
    parameter int QUEUE_DEPTH        = pfse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        format_valid,
    output logic                        format_ready,
    input  logic [7:0]                  format_char,
    output logic                        sig_valid,
    input  logic                        sig_ready,
    output logic [7:0]                  sig_char,
    output logic                        is_status,
    output logic                        ok,
    output logic [pfse_pkg::LEN_W-1:0]  sig_length,
    output logic                        last_of_run
);
    import pfse_pkg::*;

    logic  accept;
    logic  push;
    job_t  push_job;
    logic  q_full;
    logic  q_nonempty;
    logic  q_pop;
    job_t  q_head;

    assign format_ready = !q_full;
    assign accept       = format_valid && format_ready;

    pfse_front #(
        .SIGNATURE_CAPACITY (SIGNATURE_CAPACITY)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .format_char (format_char),
        .push        (push),
        .job         (push_job)
    );

    pfse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    pfse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_nonempty  (q_nonempty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .sig_valid   (sig_valid),
        .sig_ready   (sig_ready),
        .sig_char    (sig_char),
        .is_status   (is_status),
        .ok          (ok),
        .sig_length  (sig_length),
        .last_of_run (last_of_run)
    );

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        sig_valid && is_status |-> sig_char == CH_NUL && last_of_run)
        else $error("status result malformed");

    a_char_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
        sig_valid && !is_status |-> !ok && sig_length != '0)
        else $error("signature character with ok or zero length");

    a_length_steps: assert property (@(posedge clk) disable iff (!rst_n)
        sig_valid && sig_ready && !last_of_run |=>
            sig_valid && !is_status && sig_length == $past(sig_length) + LEN_W'(1))
        else $error("results of one item not consecutive");

endmodule
